>>> sv/pbdfr_pkg.sv
package pbdfr_pkg;

  // number of ports on the peripheral bus that can hold a unit
  localparam int PORT_COUNT = 4;
  localparam logic [2:0] PORT_LIMIT = 3'(PORT_COUNT);

  // bits per port in the connected map
  localparam int PORT_MAP_BITS = 6;

  // sub-unit code of the main unit
  localparam logic [2:0] SUB_MAIN = 3'd5;

  // reply header when the unit is missing
  localparam logic [31:0] RESP_MISSING = 32'hFFFF_FFFF;

  // reply header bytes
  localparam logic [10:0] HEADER_BYTES = 11'd4;

  // descriptor stride for operations other than frame transfer
  localparam logic [28:0] SKIP_STRIDE = 29'd4;

  // main RAM region code in destination bits 28:26
  localparam logic [2:0] RAM_REGION = 3'd3;

  // input item codes
  typedef enum logic [1:0] {
    OPC_VBLANK   = 2'd0,
    OPC_START    = 2'd1,
    OPC_HOLD_CLR = 2'd2,
    OPC_DESC     = 2'd3
  } opcode_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE        = 3'd0,
    REG_VBLANK_MODE   = 3'd1,
    REG_HOLD_AFTER_VB = 3'd2,
    REG_START_ADDRESS = 3'd3,
    REG_CONNECTED_MAP = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        enable;
    logic        vblank_mode;
    logic        hold_after_vblank;
    logic [28:0] start_address;
    logic [23:0] connected_map;
  } cfg_t;

  typedef struct packed {
    logic        walking;
    logic [28:0] walk_address;
    logic        hold_pending;
  } walk_state_t;

  typedef struct packed {
    opcode_t     opcode;
    logic        write_bit;
    logic [31:0] header_first;
    logic [31:0] header_second;
    logic [31:0] frame_word;
    logic [7:0]  device_response;
    logic [7:0]  device_reply_words;
  } item_t;

  typedef struct packed {
    logic        walk_start;
    logic [28:0] read_address;
    logic [31:0] dest_address;
    logic [1:0]  route_port;
    logic [2:0]  route_subport;
    logic        device_called;
    logic [31:0] response_word;
    logic [10:0] response_bytes;
    logic        frame_handled;
    logic        walk_done;
  } result_t;

endpackage

>>> sv/pbdfr_in_if.sv
interface pbdfr_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        write_bit;
  logic [31:0] header_first;
  logic [31:0] header_second;
  logic [31:0] frame_word;
  logic [7:0]  device_response;
  logic [7:0]  device_reply_words;

  modport source (
    output valid, opcode, write_bit, header_first, header_second, frame_word,
           device_response, device_reply_words,
    input  ready
  );

  modport sink (
    input  valid, opcode, write_bit, header_first, header_second, frame_word,
           device_response, device_reply_words,
    output ready
  );
endinterface

>>> sv/pbdfr_out_if.sv
interface pbdfr_out_if;
  logic        valid;
  logic        ready;
  logic        walk_start;
  logic [28:0] read_address;
  logic [31:0] dest_address;
  logic [1:0]  route_port;
  logic [2:0]  route_subport;
  logic        device_called;
  logic [31:0] response_word;
  logic [10:0] response_bytes;
  logic        frame_handled;
  logic        walk_done;

  modport source (
    output valid, walk_start, read_address, dest_address, route_port, route_subport,
           device_called, response_word, response_bytes, frame_handled, walk_done,
    input  ready
  );

  modport sink (
    input  valid, walk_start, read_address, dest_address, route_port, route_subport,
           device_called, response_word, response_bytes, frame_handled, walk_done,
    output ready
  );
endinterface

>>> sv/pbdfr_step.sv
module pbdfr_step (
  input  pbdfr_pkg::item_t       item,
  input  pbdfr_pkg::cfg_t        cfg,
  input  pbdfr_pkg::walk_state_t st,
  output pbdfr_pkg::walk_state_t st_nxt,
  output pbdfr_pkg::result_t     res
);

  logic        last;
  logic [1:0]  port;
  logic [2:0]  op;
  logic [31:0] dest_masked;
  logic [31:0] dest;
  logic [7:0]  reci;
  logic [7:0]  send;
  logic [7:0]  reci_out;
  logic [2:0]  sub;
  logic        port_ok;
  logic [5:0]  pb;
  logic        present;
  logic [8:0]  len_plus3;
  logic [28:0] frame_stride;
  logic [28:0] start_aligned;

  // descriptor field decode
  assign last        = item.header_first[31];
  assign port        = item.header_first[17:16];
  assign op          = item.header_first[10:8];
  assign reci        = item.frame_word[15:8];
  assign send        = item.frame_word[23:16];

  // destination alignment and move into main RAM
  assign dest_masked = {3'b000, item.header_second[28:5], 5'b00000};
  assign dest = (dest_masked[28:26] != pbdfr_pkg::RAM_REGION) ?
                {6'b000011, 2'b00, dest_masked[23:0]} : dest_masked;

  // lowest addressed sub-unit, sub-unit 0 when none is set
  always_comb begin
    sub = 3'd0;
    for (int i = 5; i >= 0; i--) begin
      if (reci[i]) sub = 3'(i);
    end
  end

  // units present on the addressed port
  assign port_ok = {1'b0, port} < pbdfr_pkg::PORT_LIMIT;
  assign pb      = port_ok ?
                   cfg.connected_map[5'(port) * 5'(pbdfr_pkg::PORT_MAP_BITS) +: 6] : 6'd0;
  assign present = pb[5] && ((sub == pbdfr_pkg::SUB_MAIN) || pb[sub]);
  assign reci_out = reci[5] ? (reci | {3'b000, pb[4:0]}) : reci;

  // next descriptor: header, destination and payload words
  assign len_plus3     = {1'b0, item.header_first[7:0]} + 9'd3;
  assign frame_stride  = {18'd0, len_plus3, 2'b00};
  assign start_aligned = {cfg.start_address[28:5], 5'b00000};

  // state update and result fields
  always_comb begin
    st_nxt = st;
    res    = '0;
    case (item.opcode)
      pbdfr_pkg::OPC_VBLANK: begin
        if (cfg.enable) begin
          if (!cfg.vblank_mode) begin
            st_nxt.hold_pending = 1'b0;
          end else if (!st.hold_pending && !st.walking) begin
            st_nxt.walking      = 1'b1;
            st_nxt.walk_address = start_aligned;
            res.walk_start      = 1'b1;
            if (cfg.hold_after_vblank) st_nxt.hold_pending = 1'b1;
          end
        end
      end
      pbdfr_pkg::OPC_START: begin
        if (item.write_bit && cfg.enable && !st.walking) begin
          st_nxt.walking      = 1'b1;
          st_nxt.walk_address = start_aligned;
          res.walk_start      = 1'b1;
        end
      end
      pbdfr_pkg::OPC_HOLD_CLR: begin
        if (item.write_bit) st_nxt.hold_pending = 1'b0;
      end
      pbdfr_pkg::OPC_DESC: begin
        if (st.walking) begin
          if (op == 3'd0) begin
            res.dest_address  = dest;
            res.route_port    = port;
            res.route_subport = sub;
            res.frame_handled = 1'b1;
            if (present) begin
              res.device_called  = 1'b1;
              res.response_word  = {item.device_reply_words, reci_out, send,
                                    item.device_response};
              res.response_bytes = {1'b0, item.device_reply_words, 2'b00} +
                                   pbdfr_pkg::HEADER_BYTES;
            end else begin
              res.response_word  = pbdfr_pkg::RESP_MISSING;
              res.response_bytes = pbdfr_pkg::HEADER_BYTES;
            end
            st_nxt.walk_address = st.walk_address + frame_stride;
          end else begin
            st_nxt.walk_address = st.walk_address + pbdfr_pkg::SKIP_STRIDE;
          end
          if (last) begin
            st_nxt.walking = 1'b0;
            res.walk_done  = 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.read_address = st_nxt.walk_address;
  end

endmodule

>>> sv/peripheral_bus_dma_frame_router_unit.sv
// Bus DMA frame router. Each item (vblank tick, start write, hold clear write
// or descriptor) is captured in an input register, then decoded and applied to
// the walk state as it moves on, once the output register is free; its result
// sits in the output register until taken. With the result side ready, items
// flow back to back at one per cycle. The walk state (running flag, walk
// address, vblank hold) is updated as each item leaves the input register, so
// consecutive items see each other's effect. Configuration is to be written
// through cfg_we/cfg_index/cfg_wdata only while the block is idle; the user
// must keep to this, as the block does not enforce it. Writes to indexes past
// the connected map are ignored.
module peripheral_bus_dma_frame_router_unit (
  input  logic              clk,
  input  logic              rst_n,
  pbdfr_in_if.sink          in_item,
  pbdfr_out_if.source       out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [28:0]       cfg_wdata
);

  pbdfr_pkg::cfg_t        cfg_r;
  pbdfr_pkg::walk_state_t st_r;
  pbdfr_pkg::walk_state_t st_nxt;
  pbdfr_pkg::item_t       item_r;
  pbdfr_pkg::item_t       item_in;
  pbdfr_pkg::result_t     res_nxt;
  pbdfr_pkg::result_t     res_r;
  logic                   item_valid_r;
  logic                   out_valid_r;
  logic                   advance;
  logic                   in_take;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbdfr_pkg::REG_ENABLE:        cfg_r.enable            <= cfg_wdata[0];
        pbdfr_pkg::REG_VBLANK_MODE:   cfg_r.vblank_mode       <= cfg_wdata[0];
        pbdfr_pkg::REG_HOLD_AFTER_VB: cfg_r.hold_after_vblank <= cfg_wdata[0];
        pbdfr_pkg::REG_START_ADDRESS: cfg_r.start_address     <= cfg_wdata;
        pbdfr_pkg::REG_CONNECTED_MAP: cfg_r.connected_map     <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // handshake: input register moves on whenever the output register frees up
  assign advance       = item_valid_r && (!out_valid_r || out_item.ready);
  assign in_item.ready = !item_valid_r || advance;
  assign in_take       = in_item.valid && in_item.ready;

  // input item packing
  assign item_in = '{
    opcode:             pbdfr_pkg::opcode_t'(in_item.opcode),
    write_bit:          in_item.write_bit,
    header_first:       in_item.header_first,
    header_second:      in_item.header_second,
    frame_word:         in_item.frame_word,
    device_response:    in_item.device_response,
    device_reply_words: in_item.device_reply_words
  };

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
    end else if (in_take) begin
      item_valid_r <= 1'b1;
    end else if (advance) begin
      item_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) item_r <= item_in;
  end

  // decode and walk state update
  pbdfr_step u_step (
    .item   (item_r),
    .cfg    (cfg_r),
    .st     (st_r),
    .st_nxt (st_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (advance) begin
      st_r <= st_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_item.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_r <= res_nxt;
  end

  assign out_item.valid          = out_valid_r;
  assign out_item.walk_start     = res_r.walk_start;
  assign out_item.read_address   = res_r.read_address;
  assign out_item.dest_address   = res_r.dest_address;
  assign out_item.route_port     = res_r.route_port;
  assign out_item.route_subport  = res_r.route_subport;
  assign out_item.device_called  = res_r.device_called;
  assign out_item.response_word  = res_r.response_word;
  assign out_item.response_bytes = res_r.response_bytes;
  assign out_item.frame_handled  = res_r.frame_handled;
  assign out_item.walk_done      = res_r.walk_done;

  // a finished walk leaves the block idle
  a_done_stops_walk: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.walk_done |=> !st_r.walking)
    else $error("walk still running after its last descriptor");

  // input side stalls only when both registers are full and the output waits
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_item.ready |-> item_valid_r && out_valid_r && !out_item.ready)
    else $error("input stalled with room in the pipeline");

  // a started walk always shows the aligned start address
  a_start_address: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res_nxt.walk_start |=> st_r.walking && (st_r.walk_address[4:0] == 5'd0))
    else $error("walk started without an aligned address");

endmodule
